// ===== src/rmr_pkg.sv =====
`default_nettype none
package rmr_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS  = 16;
	localparam int CFG_WIDTH  = 2;

	// register indexes of the configuration port
	localparam logic [CFG_WIDTH-1:0] REG_KM_SUBSTRATE = 2'd0;
	localparam logic [CFG_WIDTH-1:0] REG_KM_PRODUCT   = 2'd1;
	localparam logic [CFG_WIDTH-1:0] REG_KCAT_FORWARD = 2'd2;
	localparam logic [CFG_WIDTH-1:0] REG_KCAT_REVERSE = 2'd3;

	// result status codes
	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_SATURATED = 2'd1;
	localparam logic [1:0] STATUS_ZERO_DEN  = 2'd2;

	typedef struct packed {
		logic [DATA_WIDTH-1:0] substrate_conc;
		logic [DATA_WIDTH-1:0] product_conc;
		logic [DATA_WIDTH-1:0] enzyme_amount;
	} item_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] flux_velocity;
		logic [1:0]                   status;
	} result_t;

endpackage
`default_nettype wire

// ===== src/reversible_michaelis_rate.sv =====
`default_nettype none
// channel  | valid        | stall        | payload
// ---------+--------------+--------------+---------------------------------
// item     | item_valid   | item_stall   | item   (rmr_pkg::item_t)
// result   | result_valid | result_stall | result (rmr_pkg::result_t)
// config   | cfg_we       | (none)       | cfg_index, cfg_data
//
// one transaction enters per cycle unless a stalled output holds the pipeline; each passes through
// seven arithmetic stages, one divider stage per quotient bit and the output register
// the quotient bits come from a restoring divider unrolled into DATA_WIDTH stages
// arst_n clears all valid bits and loads every constant with 1.0
// a stalled full output register freezes the whole pipeline; item_stall follows it
module reversible_michaelis_rate #(
	parameter int FRAC_BITS = rmr_pkg::FRAC_BITS
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          item_valid,
	output logic                               item_stall,
	input  wire rmr_pkg::item_t                item,
	output logic                               result_valid,
	input  wire logic                          result_stall,
	output rmr_pkg::result_t                   result,
	input  wire logic                          cfg_we,
	input  wire logic [rmr_pkg::CFG_WIDTH-1:0] cfg_index,
	input  wire logic [rmr_pkg::DATA_WIDTH-1:0] cfg_data
);

	localparam int W  = rmr_pkg::DATA_WIDTH;
	localparam int DW = 2 * W + 2;              // denominator before scaling
	localparam int NW = 4 * W + FRAC_BITS + 2;  // divider working width

	// configuration registers; the user must write them only while idle, the block does not enforce it
	logic [W-1:0] ks_q, kp_q, kf_q, kr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ks_q <= W'(1) << FRAC_BITS;
			kp_q <= W'(1) << FRAC_BITS;
			kf_q <= W'(1) << FRAC_BITS;
			kr_q <= W'(1) << FRAC_BITS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rmr_pkg::REG_KM_SUBSTRATE: ks_q <= cfg_data;
				rmr_pkg::REG_KM_PRODUCT:   kp_q <= cfg_data;
				rmr_pkg::REG_KCAT_FORWARD: kf_q <= cfg_data;
				rmr_pkg::REG_KCAT_REVERSE: kr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// whole pipeline moves unless the output holds a transaction nobody takes
	logic adv;
	assign adv        = !(result_valid && result_stall);
	assign item_stall = !adv;

	// stage 1: the five constant and concentration products
	logic           v_s1;
	logic [2*W-1:0] ksp_s1, kps_s1, kskp_s1, kfkp_s1, krks_s1;
	logic [W-1:0]   s_s1, p_s1, e_s1;

	// stage 2: denominator sum, split products of the numerator terms
	logic           v_s2;
	logic [DW-1:0]  den_s2;
	logic [2*W-1:0] fl_s2, fh_s2, rl_s2, rh_s2;
	logic [W-1:0]   e_s2;

	// stage 3: assembled forward and reverse terms
	logic           v_s3;
	logic [DW-1:0]  den_s3;
	logic [3*W-1:0] fwd_s3, rev_s3;
	logic [W-1:0]   e_s3;

	// stage 4: magnitude and sign of the difference
	logic           v_s4, neg_s4;
	logic [DW-1:0]  den_s4;
	logic [3*W-1:0] mag_s4;
	logic [W-1:0]   e_s4;

	// stage 5: partial products of magnitude times enzyme
	logic           v_s5, neg_s5;
	logic [DW-1:0]  den_s5;
	logic [2*W-1:0] pm0_s5, pm1_s5, pm2_s5;

	// stage 6: full numerator and scaled denominator
	logic           v_s6, neg_s6, zero_s6;
	logic [4*W-1:0] num_s6;
	logic [NW-1:0]  den_s6;

	// stage 7: quotient overflow check
	logic           v_s7, neg_s7, zero_s7, ovf_s7;
	logic [NW-1:0]  rem_s7, den_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s1 <= item_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ksp_s1  <= ks_q * item.product_conc;
			kps_s1  <= kp_q * item.substrate_conc;
			kskp_s1 <= ks_q * kp_q;
			kfkp_s1 <= kf_q * kp_q;
			krks_s1 <= kr_q * ks_q;
			s_s1    <= item.substrate_conc;
			p_s1    <= item.product_conc;
			e_s1    <= item.enzyme_amount;

			den_s2 <= DW'(ksp_s1) + DW'(kps_s1) + DW'(kskp_s1);
			fl_s2  <= kfkp_s1[W-1:0] * s_s1;
			fh_s2  <= kfkp_s1[2*W-1:W] * s_s1;
			rl_s2  <= krks_s1[W-1:0] * p_s1;
			rh_s2  <= krks_s1[2*W-1:W] * p_s1;
			e_s2   <= e_s1;

			den_s3 <= den_s2;
			fwd_s3 <= (3*W)'(fl_s2) + ((3*W)'(fh_s2) << W);
			rev_s3 <= (3*W)'(rl_s2) + ((3*W)'(rh_s2) << W);
			e_s3   <= e_s2;

			den_s4 <= den_s3;
			neg_s4 <= fwd_s3 < rev_s3;
			mag_s4 <= (fwd_s3 < rev_s3) ? rev_s3 - fwd_s3 : fwd_s3 - rev_s3;
			e_s4   <= e_s3;

			den_s5 <= den_s4;
			neg_s5 <= neg_s4;
			pm0_s5 <= mag_s4[W-1:0] * e_s4;
			pm1_s5 <= mag_s4[2*W-1:W] * e_s4;
			pm2_s5 <= mag_s4[3*W-1:2*W] * e_s4;

			neg_s6  <= neg_s5;
			zero_s6 <= den_s5 == '0;
			num_s6  <= (4*W)'(pm0_s5) + ((4*W)'(pm1_s5) << W) + ((4*W)'(pm2_s5) << (2*W));
			den_s6  <= NW'(den_s5) << FRAC_BITS;

			neg_s7  <= neg_s6;
			zero_s7 <= zero_s6;
			ovf_s7  <= NW'(num_s6) >= (den_s6 << W);
			rem_s7  <= NW'(num_s6);
			den_s7  <= den_s6;
		end
	end

	// divider: stage k decides quotient bit W-1-k
	logic          dv_s   [W+1];
	logic          dneg_s [W+1];
	logic          dzero_s[W+1];
	logic          dovf_s [W+1];
	logic [NW-1:0] drem_s [W+1];
	logic [NW-1:0] dden_s [W+1];
	logic [W-1:0]  dq_s   [W+1];

	assign dv_s[0]    = v_s7;
	assign dneg_s[0]  = neg_s7;
	assign dzero_s[0] = zero_s7;
	assign dovf_s[0]  = ovf_s7;
	assign drem_s[0]  = rem_s7;
	assign dden_s[0]  = den_s7;
	assign dq_s[0]    = '0;

	for (genvar k = 0; k < W; k++) begin : g_div
		localparam int B = W - 1 - k;
		logic [NW-1:0] trial;
		logic          ge;
		logic [W-1:0]  q_next;

		assign trial = dden_s[k] << B;
		assign ge    = drem_s[k] >= trial;
		always_comb begin
			q_next    = dq_s[k];
			q_next[B] = ge;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_s[k+1] <= 1'b0;
			end else if (adv) begin
				dv_s[k+1] <= dv_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dneg_s[k+1]  <= dneg_s[k];
				dzero_s[k+1] <= dzero_s[k];
				dovf_s[k+1]  <= dovf_s[k];
				drem_s[k+1]  <= ge ? drem_s[k] - trial : drem_s[k];
				dden_s[k+1]  <= dden_s[k];
				dq_s[k+1]    <= q_next;
			end
		end
	end

	// saturate to the signed range and apply the sign
	logic [W-1:0] lim, mag_out;
	logic         sat;

	always_comb begin
		lim     = dneg_s[W] ? (W'(1) << (W - 1)) : ((W'(1) << (W - 1)) - W'(1));
		sat     = dovf_s[W] || (dq_s[W] > lim);
		mag_out = sat ? lim : dq_s[W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (adv) begin
			result_valid <= dv_s[W];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			priority if (dzero_s[W]) begin
				result.flux_velocity <= '0;
				result.status        <= rmr_pkg::STATUS_ZERO_DEN;
			end else begin
				result.flux_velocity <= dneg_s[W] ? -mag_out : mag_out;
				result.status        <= sat ? rmr_pkg::STATUS_SATURATED : rmr_pkg::STATUS_OK;
			end
		end
	end

	a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (result_valid && result_stall))
		else $error("input stalled while output free");

	a_zero_den_gives_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.status == rmr_pkg::STATUS_ZERO_DEN) |-> result.flux_velocity == '0)
		else $error("zero denominator with nonzero velocity");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.status != 2'd3))
		else $error("undefined status code");

	a_hold_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> ($stable(result) && result_valid))
		else $error("stalled result changed");

endmodule
`default_nettype wire

// ===== dv/tb_reversible_michaelis_rate.sv =====
`default_nettype none
module tb_reversible_michaelis_rate;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY    = rmr_pkg::DATA_WIDTH + 8;
	localparam int PHASES     = 8;
	localparam int PHASE_ITEMS = 200;
	localparam logic [rmr_pkg::DATA_WIDTH-1:0] ONE      =
		rmr_pkg::DATA_WIDTH'(1) << rmr_pkg::FRAC_BITS;
	localparam logic [rmr_pkg::DATA_WIDTH-1:0] WORD_MAX = '1;

	typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

	// one line of the directed table: either a register write or an item
	typedef struct {
		row_kind_t                          kind;
		logic [rmr_pkg::CFG_WIDTH-1:0]      idx;
		logic [rmr_pkg::DATA_WIDTH-1:0]     data;
		rmr_pkg::item_t                     it;
		bit                                 typed;
		rmr_pkg::result_t                   exp;
	} row_t;

	logic                           clk;
	logic                           arst_n;
	logic                           item_valid;
	logic                           item_stall;
	rmr_pkg::item_t                 item;
	logic                           result_valid;
	logic                           result_stall;
	rmr_pkg::result_t               result;
	logic                           cfg_we;
	logic [rmr_pkg::CFG_WIDTH-1:0]  cfg_index;
	logic [rmr_pkg::DATA_WIDTH-1:0] cfg_data;

	reversible_michaelis_rate u_top (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall), .item(item),
		.result_valid(result_valid), .result_stall(result_stall), .result(result),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// mirror of the rate constants, updated on every register write
	logic [rmr_pkg::DATA_WIDTH-1:0] km_s, km_p, kcat_f, kcat_r;

	rmr_pkg::result_t pending_flux[$];
	row_t    directed[$];
	int      errors;
	int      tx_idle_pct;
	int      rx_idle_pct;
	int      hold_cycles;
	int      n_ok, n_sat, n_zero;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// exact rate law on wide vectors, truncated toward zero, then saturated
	function automatic rmr_pkg::result_t predict_flux(rmr_pkg::item_t it);
		bit [255:0] s, p, e, ks, kp, kf, kr, den, fwd, rev, mag, q, lim;
		bit         neg;
		rmr_pkg::result_t r;
		s = it.substrate_conc;
		p = it.product_conc;
		e = it.enzyme_amount;
		ks = km_s;
		kp = km_p;
		kf = kcat_f;
		kr = kcat_r;
		den = ks * p + kp * s + ks * kp;
		if (den == 0) begin
			r.flux_velocity = '0;
			r.status = rmr_pkg::STATUS_ZERO_DEN;
			return r;
		end
		den = den << rmr_pkg::FRAC_BITS;
		fwd = kf * kp * s;
		rev = kr * ks * p;
		neg = fwd < rev;
		mag = neg ? rev - fwd : fwd - rev;
		q = (mag * e) / den;
		lim = 256'd1 << (rmr_pkg::DATA_WIDTH - 1);
		if (!neg)
			lim = lim - 1;
		r.status = rmr_pkg::STATUS_OK;
		if (q > lim) begin
			q = lim;
			r.status = rmr_pkg::STATUS_SATURATED;
		end
		r.flux_velocity = neg ? -q[rmr_pkg::DATA_WIDTH-1:0] : q[rmr_pkg::DATA_WIDTH-1:0];
		return r;
	endfunction

	// biased word: corners and small values show up far more than pure random
	function automatic logic [rmr_pkg::DATA_WIDTH-1:0] pick_word();
		case ($urandom_range(7))
			0: return '0;
			1: return WORD_MAX;
			2: return ONE;
			3, 4: return $urandom_range(0, 1 << 20);
			default: return $urandom;
		endcase
	endfunction

	function automatic void add_cfg(logic [rmr_pkg::CFG_WIDTH-1:0] idx,
			logic [rmr_pkg::DATA_WIDTH-1:0] data);
		row_t r;
		r.kind = ROW_CFG;
		r.idx = idx;
		r.data = data;
		r.it = '0;
		r.typed = 1'b0;
		r.exp = '0;
		directed.push_back(r);
	endfunction

	function automatic void add_item(logic [rmr_pkg::DATA_WIDTH-1:0] s,
			logic [rmr_pkg::DATA_WIDTH-1:0] p, logic [rmr_pkg::DATA_WIDTH-1:0] e,
			bit typed, logic [rmr_pkg::DATA_WIDTH-1:0] v, logic [1:0] st);
		row_t r;
		r.kind = ROW_ITEM;
		r.idx = '0;
		r.data = '0;
		r.it = '{substrate_conc: s, product_conc: p, enzyme_amount: e};
		r.typed = typed;
		r.exp = '{flux_velocity: v, status: st};
		directed.push_back(r);
	endfunction

	// register writes wait for the pipeline to drain first
	task automatic write_reg(logic [rmr_pkg::CFG_WIDTH-1:0] idx,
			logic [rmr_pkg::DATA_WIDTH-1:0] data);
		while (pending_flux.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			rmr_pkg::REG_KM_SUBSTRATE: km_s = data;
			rmr_pkg::REG_KM_PRODUCT:   km_p = data;
			rmr_pkg::REG_KCAT_FORWARD: kcat_f = data;
			default:                   kcat_r = data;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// offer one transaction, with random idle cycles ahead of it
	task automatic send_item(rmr_pkg::item_t it, bit typed, rmr_pkg::result_t exp);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do
			@(posedge clk);
		while (item_stall);
		pending_flux.push_back(typed ? exp : predict_flux(it));
	endtask

	// receiver: a long hold-off when asked, otherwise random stalls
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			result_stall <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else begin
			result_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	// result checker, oldest expectation first
	always @(posedge clk) begin
		rmr_pkg::result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_flux.size() == 0) begin
				$error("result transaction with nothing expected: velocity %0d status %0d",
					result.flux_velocity, result.status);
				errors++;
			end else begin
				want = pending_flux.pop_front();
				if (result.flux_velocity !== want.flux_velocity) begin
					$error("flux_velocity expected %0d actual %0d",
						want.flux_velocity, result.flux_velocity);
					errors++;
				end
				if (result.status !== want.status) begin
					$error("status expected %0d actual %0d", want.status, result.status);
					errors++;
				end
				case (result.status)
					rmr_pkg::STATUS_OK:        n_ok++;
					rmr_pkg::STATUS_SATURATED: n_sat++;
					default:                   n_zero++;
				endcase
			end
		end
	end

	// watchdog
	initial begin
		#20ms;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		rmr_pkg::item_t   it;
		rmr_pkg::result_t none;
		errors = 0;
		n_ok = 0;
		n_sat = 0;
		n_zero = 0;
		hold_cycles = 0;
		tx_idle_pct = 23;
		rx_idle_pct = 46;
		none = '0;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		result_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		km_s = ONE;
		km_p = ONE;
		kcat_f = ONE;
		kcat_r = ONE;

		// reset constants are all 1.0
		add_item('0, '0, '0, 1, '0, rmr_pkg::STATUS_OK);
		add_item('0, '0, WORD_MAX, 1, '0, rmr_pkg::STATUS_OK);
		add_item(WORD_MAX, WORD_MAX, '0, 1, '0, rmr_pkg::STATUS_OK);
		add_item(WORD_MAX, '0, WORD_MAX, 1, 32'h7fff_ffff, rmr_pkg::STATUS_SATURATED);
		add_item('0, WORD_MAX, WORD_MAX, 1, 32'h8000_0000, rmr_pkg::STATUS_SATURATED);
		add_item(ONE, ONE, ONE, 0, '0, rmr_pkg::STATUS_OK);
		add_item(2 * ONE, ONE, ONE, 0, '0, rmr_pkg::STATUS_OK);
		add_item(ONE, 3 * ONE, ONE, 0, '0, rmr_pkg::STATUS_OK);
		// both Michaelis constants zero: every denominator vanishes
		add_cfg(rmr_pkg::REG_KM_SUBSTRATE, '0);
		add_cfg(rmr_pkg::REG_KM_PRODUCT, '0);
		add_item(WORD_MAX, WORD_MAX, WORD_MAX, 1, '0, rmr_pkg::STATUS_ZERO_DEN);
		add_item('0, '0, '0, 1, '0, rmr_pkg::STATUS_ZERO_DEN);
		add_item(ONE, '0, ONE, 1, '0, rmr_pkg::STATUS_ZERO_DEN);
		// only substrate Km zero: the denominator is Kp*S
		add_cfg(rmr_pkg::REG_KM_PRODUCT, ONE);
		add_item('0, WORD_MAX, WORD_MAX, 1, '0, rmr_pkg::STATUS_ZERO_DEN);
		add_item(ONE, WORD_MAX, WORD_MAX, 0, '0, rmr_pkg::STATUS_OK);
		// largest constants, forward only then reverse only
		add_cfg(rmr_pkg::REG_KM_SUBSTRATE, WORD_MAX);
		add_cfg(rmr_pkg::REG_KM_PRODUCT, WORD_MAX);
		add_cfg(rmr_pkg::REG_KCAT_FORWARD, WORD_MAX);
		add_cfg(rmr_pkg::REG_KCAT_REVERSE, '0);
		add_item(WORD_MAX, WORD_MAX, WORD_MAX, 0, '0, rmr_pkg::STATUS_OK);
		add_item(1, '0, 1, 0, '0, rmr_pkg::STATUS_OK);
		add_cfg(rmr_pkg::REG_KCAT_FORWARD, '0);
		add_cfg(rmr_pkg::REG_KCAT_REVERSE, WORD_MAX);
		add_item(WORD_MAX, WORD_MAX, WORD_MAX, 0, '0, rmr_pkg::STATUS_OK);
		add_item('0, 1, WORD_MAX, 0, '0, rmr_pkg::STATUS_OK);

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed[i]) begin
			if (directed[i].kind == ROW_CFG) begin
				@(negedge clk);
				item_valid <= 1'b0;
				write_reg(directed[i].idx, directed[i].data);
			end else begin
				send_item(directed[i].it, directed[i].typed, directed[i].exp);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			@(negedge clk);
			item_valid <= 1'b0;
			// idle pattern: sender light / receiver heavy, swapped, then none
			if (ph < 3) begin
				tx_idle_pct = 23;
				rx_idle_pct = 46;
			end else if (ph < 6) begin
				tx_idle_pct = 46;
				rx_idle_pct = 23;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			// first phase takes the largest constants, second the smallest nonzero
			write_reg(rmr_pkg::REG_KM_SUBSTRATE,
				ph == 0 ? WORD_MAX : ph == 1 ? 32'd1 : pick_word());
			write_reg(rmr_pkg::REG_KM_PRODUCT,
				ph == 0 ? WORD_MAX : ph == 1 ? 32'd1 : pick_word());
			write_reg(rmr_pkg::REG_KCAT_FORWARD,
				ph == 0 ? WORD_MAX : ph == 1 ? 32'd1 : pick_word());
			write_reg(rmr_pkg::REG_KCAT_REVERSE,
				ph == 0 ? WORD_MAX : ph == 1 ? 32'd1 : pick_word());
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// long receiver hold-off with no sender gaps: pipeline backs up
				if (ph == 6 && n == 20)
					hold_cycles = 3 * LATENCY;
				it.substrate_conc = pick_word();
				it.product_conc = pick_word();
				it.enzyme_amount = pick_word();
				send_item(it, 0, none);
			end
		end
		@(negedge clk);
		item_valid <= 1'b0;

		while (pending_flux.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);

		$display("covered %0d results: %0d in range, %0d saturated, %0d zero denominator",
			n_ok + n_sat + n_zero, n_ok, n_sat, n_zero);
		$display("directed corners plus %0d constant settings under three stall patterns",
			PHASES);
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
`default_nettype wire
